// ===== sv/csp_pkg.sv =====
package csp_pkg;

  // Defaults for the top-level parameters
  localparam int LOOKAHEAD_DEF    = 4;
  localparam int MAX_CHANNELS_DEF = 64;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int RSSI_W = 8;
  localparam int TUNE_W = 6;
  localparam int PHASE_W = 2;
  localparam int THR_W  = 8;
  localparam int CNT_CFG_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Register reset values
  localparam logic [THR_W-1:0]     THR_RST = 8'd80;
  localparam logic [CNT_CFG_W-1:0] CNT_RST = 7'd40;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DOWN = 2'd2;

  // Phases
  localparam logic [PHASE_W-1:0] PHASE_SCAN = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_PEAK = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_LOCK = 2'd2;

  // Datapath operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
  localparam logic [OP_W-1:0] OP_TAKE   = 3'd1;
  localparam logic [OP_W-1:0] OP_BUTTON = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP   = 3'd3;
  localparam logic [OP_W-1:0] OP_START  = 3'd4;
  localparam logic [OP_W-1:0] OP_PWRITE = 3'd5;
  localparam logic [OP_W-1:0] OP_MAX    = 3'd6;
  localparam logic [OP_W-1:0] OP_DECIDE = 3'd7;

  // Jump conditions
  localparam int CND_W = 4;
  localparam logic [CND_W-1:0] C_ALWAYS     = 4'd0;
  localparam logic [CND_W-1:0] C_IN_TAKEN   = 4'd1;
  localparam logic [CND_W-1:0] C_BUTTON     = 4'd2;
  localparam logic [CND_W-1:0] C_SCAN_TICK  = 4'd3;
  localparam logic [CND_W-1:0] C_NOT_PTICK  = 4'd4;
  localparam logic [CND_W-1:0] C_START_PEAK = 4'd5;
  localparam logic [CND_W-1:0] C_PEAK_CONT  = 4'd6;
  localparam logic [CND_W-1:0] C_MORE       = 4'd7;
  localparam logic [CND_W-1:0] C_OUT_FREE   = 4'd8;

  // Program steps
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] S_DISP   = 4'd1;
  localparam logic [PC_W-1:0] S_DISP2  = 4'd2;
  localparam logic [PC_W-1:0] S_DISP3  = 4'd3;
  localparam logic [PC_W-1:0] S_PWRITE = 4'd4;
  localparam logic [PC_W-1:0] S_MAX    = 4'd5;
  localparam logic [PC_W-1:0] S_DECIDE = 4'd6;
  localparam logic [PC_W-1:0] S_BTN    = 4'd7;
  localparam logic [PC_W-1:0] S_SCAN   = 4'd8;
  localparam logic [PC_W-1:0] S_STEP   = 4'd9;
  localparam logic [PC_W-1:0] S_START  = 4'd10;
  localparam logic [PC_W-1:0] S_EMIT   = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cond;
    logic             hold;   // stay on this step while the condition is false
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic in_taken;
    logic out_free;
    logic button;
    logic scan_tick;
    logic not_ptick;
    logic start_peak;
    logic peak_cont;
    logic more;
  } cond_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            take;
    logic            emit;
  } ctrl_t;

  function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, hold: 1'b0, target: S_IDLE};
    unique case (pc)
      S_IDLE:   w = '{op: OP_TAKE,   cond: C_IN_TAKEN,   hold: 1'b1, target: S_DISP};
      S_DISP:   w = '{op: OP_NOP,    cond: C_BUTTON,     hold: 1'b0, target: S_BTN};
      S_DISP2:  w = '{op: OP_NOP,    cond: C_SCAN_TICK,  hold: 1'b0, target: S_SCAN};
      S_DISP3:  w = '{op: OP_NOP,    cond: C_NOT_PTICK,  hold: 1'b0, target: S_EMIT};
      S_PWRITE: w = '{op: OP_PWRITE, cond: C_PEAK_CONT,  hold: 1'b0, target: S_EMIT};
      S_MAX:    w = '{op: OP_MAX,    cond: C_MORE,       hold: 1'b0, target: S_MAX};
      S_DECIDE: w = '{op: OP_DECIDE, cond: C_ALWAYS,     hold: 1'b0, target: S_EMIT};
      S_BTN:    w = '{op: OP_BUTTON, cond: C_ALWAYS,     hold: 1'b0, target: S_EMIT};
      S_SCAN:   w = '{op: OP_NOP,    cond: C_START_PEAK, hold: 1'b0, target: S_START};
      S_STEP:   w = '{op: OP_STEP,   cond: C_ALWAYS,     hold: 1'b0, target: S_EMIT};
      S_START:  w = '{op: OP_START,  cond: C_ALWAYS,     hold: 1'b0, target: S_EMIT};
      S_EMIT:   w = '{op: OP_NOP,    cond: C_OUT_FREE,   hold: 1'b1, target: S_IDLE};
      default:  w = '{op: OP_NOP,    cond: C_ALWAYS,     hold: 1'b0, target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/csp_sequencer.sv =====
module csp_sequencer
  import csp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cond_t cond,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ucode_t          cw;
  logic            taken;

  assign cw = ucode_word(pc_r);

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:     taken = 1'b1;
      C_IN_TAKEN:   taken = cond.in_taken;
      C_BUTTON:     taken = cond.button;
      C_SCAN_TICK:  taken = cond.scan_tick;
      C_NOT_PTICK:  taken = cond.not_ptick;
      C_START_PEAK: taken = cond.start_peak;
      C_PEAK_CONT:  taken = cond.peak_cont;
      C_MORE:       taken = cond.more;
      C_OUT_FREE:   taken = cond.out_free;
      default:      taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_nxt = cw.target;
    end else if (cw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op   = cw.op;
  assign ctrl.take = (pc_r == S_IDLE);
  assign ctrl.emit = (pc_r == S_EMIT) && cond.out_free;

endmodule

// ===== sv/csp_datapath.sv =====
module csp_datapath
  import csp_pkg::*;
#(
  parameter int LOOKAHEAD    = LOOKAHEAD_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int IDX_W = $clog2(MAX_CHANNELS)
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_t                ctrl,
  input  logic                 in_fire,
  input  logic                 out_free,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [RSSI_W-1:0]    in_rssi,
  input  logic [THR_W-1:0]     cfg_thr,
  input  logic [CNT_CFG_W-1:0] cfg_cnt,
  output cond_t                cond,
  output logic [IDX_W-1:0]     res_index,
  output logic                 res_retune,
  output logic [PHASE_W-1:0]   res_phase
);

  localparam int CNT_W  = IDX_W + 1;
  localparam int SLOT_W = (LOOKAHEAD > 1) ? $clog2(LOOKAHEAD) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LOOKAHEAD - 1);
  localparam logic [SLOT_W:0]   SLOT_LIM  = (SLOT_W + 1)'(LOOKAHEAD);

  // control state
  logic             scan_r, peak_r, down_r, skip_r;
  logic [IDX_W-1:0] base_r;
  logic [CNT_W-1:0] probe_r;

  // payload
  logic [CMD_W-1:0]  cmd_r;
  logic [RSSI_W-1:0] rssi_r;
  logic [CNT_W-1:0]  before_r;
  logic [SLOT_W-1:0] slot_r, idx_r, best_r;
  logic [RSSI_W-1:0] best_val_r;
  logic [RSSI_W-1:0] samp_r [LOOKAHEAD];

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] tuned;
  logic [CNT_W-1:0] step_raw;
  logic [IDX_W-1:0] step_idx;
  logic             tick;

  always_comb begin
    if (cfg_cnt == '0) begin
      count = CNT_W'(1);
    end else if (int'(cfg_cnt) > MAX_CHANNELS) begin
      count = CNT_W'(MAX_CHANNELS);
    end else begin
      count = CNT_W'(cfg_cnt);
    end
  end

  assign tuned = peak_r ? probe_r : {1'b0, base_r};

  // one scan step with wrap at both ends
  always_comb begin
    if (down_r) begin
      step_raw = (base_r == '0) ? (count - 1'b1) : ({1'b0, base_r} - 1'b1);
    end else begin
      step_raw = {1'b0, base_r} + 1'b1;
    end
    step_idx = (step_raw >= count) ? '0 : step_raw[IDX_W-1:0];
  end

  assign tick            = (cmd_r == CMD_TICK);
  assign cond.in_taken   = in_fire;
  assign cond.out_free   = out_free;
  assign cond.button     = (cmd_r == CMD_UP) || (cmd_r == CMD_DOWN);
  assign cond.scan_tick  = tick && !peak_r && scan_r;
  assign cond.not_ptick  = !(tick && peak_r);
  assign cond.start_peak = !skip_r && (rssi_r >= cfg_thr);
  assign cond.peak_cont  = (({1'b0, slot_r} + 1'b1) < SLOT_LIM)
                        && (({1'b0, probe_r} + 1'b1) < {1'b0, count});
  assign cond.more       = (idx_r != LAST_SLOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= 1'b1;
      peak_r  <= 1'b0;
      down_r  <= 1'b0;
      skip_r  <= 1'b0;
      base_r  <= '0;
      probe_r <= '0;
    end else begin
      case (ctrl.op)
        OP_BUTTON: begin
          scan_r <= 1'b1;
          skip_r <= 1'b1;
          down_r <= (cmd_r == CMD_DOWN);
        end
        OP_STEP: begin
          base_r <= step_idx;
          skip_r <= 1'b0;
        end
        OP_START: begin
          scan_r  <= 1'b0;
          peak_r  <= 1'b1;
          probe_r <= {1'b0, base_r};
        end
        OP_PWRITE: begin
          probe_r <= probe_r + 1'b1;
        end
        OP_DECIDE: begin
          base_r <= base_r + IDX_W'(best_r);
          peak_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_TAKE: begin
        if (in_fire) begin
          cmd_r    <= in_cmd;
          rssi_r   <= in_rssi;
          before_r <= tuned;
        end
      end
      OP_START: begin
        slot_r <= '0;
        for (int i = 0; i < LOOKAHEAD; i++) begin
          samp_r[i] <= '0;
        end
      end
      OP_PWRITE: begin
        samp_r[slot_r] <= rssi_r;
        slot_r         <= slot_r + 1'b1;
        idx_r          <= '0;
        best_r         <= '0;
        best_val_r     <= '0;
      end
      OP_MAX: begin
        // strict compare keeps the lowest index on a tie
        if (samp_r[idx_r] > best_val_r) begin
          best_val_r <= samp_r[idx_r];
          best_r     <= idx_r;
        end
        idx_r <= idx_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_index  = tuned[IDX_W-1:0];
  assign res_retune = (tuned != before_r);
  assign res_phase  = peak_r ? PHASE_PEAK : (scan_r ? PHASE_SCAN : PHASE_LOCK);

endmodule

// ===== sv/channel_seek_with_peak_lookahead.sv =====
// Channel     | Handshake            | Payload
// ------------+----------------------+------------------------------------------
// input       | in_valid / in_ready  | in_cmd, in_rssi
// result      | out_valid / out_ready| out_tune_index, out_retune, out_phase
// config      | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One item is in flight at a time; a microcode program steps through it.
// The steps from the input transfer to the result register load differ by item: button,
// ignored item or locked tick, scan tick, peak sample, final peak sample (adds a serial max).
// The input is taken again on the cycle after the result register loads.
// Reset (rst_n low, synchronous) scans upward from channel 0, threshold 80, 40 channels.
// A stalled result holds the program on its emit step; no new item is taken meanwhile.
module channel_seek_with_peak_lookahead
  import csp_pkg::*;
#(
  parameter int LOOKAHEAD    = LOOKAHEAD_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [RSSI_W-1:0]     in_rssi,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TUNE_W-1:0]     out_tune_index,
  output logic                  out_retune,
  output logic [PHASE_W-1:0]    out_phase,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_CHANNELS);

  logic [THR_W-1:0]     thr_r;
  logic [CNT_CFG_W-1:0] cnt_r;

  logic                 out_valid_r;
  logic [TUNE_W-1:0]    out_tune_r;
  logic                 out_retune_r;
  logic [PHASE_W-1:0]   out_phase_r;

  ctrl_t                ctrl;
  cond_t                cond;
  logic                 in_fire;
  logic                 out_free;
  logic [IDX_W-1:0]     res_index;
  logic                 res_retune;
  logic [PHASE_W-1:0]   res_phase;
  logic [IDX_W+TUNE_W-1:0] res_ext;

  // configuration registers: writes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
      cnt_r <= CNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_THRESHOLD) begin
        thr_r <= cfg_wdata[THR_W-1:0];
      end else if (cfg_index == CFG_COUNT) begin
        cnt_r <= cfg_wdata[CNT_CFG_W-1:0];
      end
    end
  end

  assign in_ready = ctrl.take;
  assign in_fire  = in_valid && in_ready;
  // the result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  csp_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctrl  (ctrl)
  );

  csp_datapath #(
    .LOOKAHEAD    (LOOKAHEAD),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_fire    (in_fire),
    .out_free   (out_free),
    .in_cmd     (in_cmd),
    .in_rssi    (in_rssi),
    .cfg_thr    (thr_r),
    .cfg_cnt    (cnt_r),
    .cond       (cond),
    .res_index  (res_index),
    .res_retune (res_retune),
    .res_phase  (res_phase)
  );

  // fit the internal index to the port: pad or truncate
  assign res_ext = {{TUNE_W{1'b0}}, res_index};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the payload until the transfer; load only on emit
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_tune_r   <= res_ext[TUNE_W-1:0];
      out_retune_r <= res_retune;
      out_phase_r  <= res_phase;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tune_index = out_tune_r;
  assign out_retune     = out_retune_r;
  assign out_phase      = out_phase_r;

endmodule

// ===== sv/csp_checker.sv =====
module csp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_tune_index,
  input logic       out_retune,
  input logic [1:0] out_phase
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tune_index)
      && $stable(out_retune) && $stable(out_phase))
    else $error("result changed while stalled");

  // one item at a time: no input transfer in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind channel_seek_with_peak_lookahead csp_checker u_csp_checker (.*);
